// ===== rtl/stream_pattern_substitute_append_assert.svh =====
// ----------------------------------------------------------------------------
// stream_pattern_substitute_append assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset aware
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_SUBSTITUTE_APPEND_ASSERT_SVH
`define STREAM_PATTERN_SUBSTITUTE_APPEND_ASSERT_SVH

// same-cycle implication
`define SPSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spsa assertion failed");

// next-cycle implication
`define SPSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spsa assertion failed");

`endif

// ===== rtl/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// spsa_pkg
// shared types, constants and the message rom for the pattern substitute block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsa_pkg;

	localparam int BUFFER_BYTES_DEF  = 1024;
	localparam int MESSAGE_BYTES_DEF = 38;
	localparam int MSG_ROM_SLOTS     = 64;
	localparam int JOBQ_DEPTH        = 4;
	localparam int ADDR_W            = 10;

	localparam logic [7:0] PAT_0 = 8'h55;
	localparam logic [7:0] PAT_1 = 8'h43;
	localparam logic [7:0] PAT_2 = 8'h46;

	typedef enum logic {
		JOB_BYTES = 1'b0,
		JOB_MSG   = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [1:0]       nbytes;
		logic [2:0][7:0]  bytes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jobq_status_t;

	function automatic logic [7:0] msg_rom_byte(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:  b = 8'h55;
			6'd1:  b = 8'h6E;
			6'd2:  b = 8'h64;
			6'd3:  b = 8'h65;
			6'd4:  b = 8'h66;
			6'd5:  b = 8'h65;
			6'd6:  b = 8'h61;
			6'd7:  b = 8'h74;
			6'd8:  b = 8'h65;
			6'd9:  b = 8'h64;
			6'd10: b = 8'h20;
			6'd11: b = 8'h32;
			6'd12: b = 8'h30;
			6'd13: b = 8'h31;
			6'd14: b = 8'h38;
			6'd15: b = 8'h20;
			6'd16: b = 8'h4E;
			6'd17: b = 8'h61;
			6'd18: b = 8'h74;
			6'd19: b = 8'h69;
			6'd20: b = 8'h6F;
			6'd21: b = 8'h6E;
			6'd22: b = 8'h61;
			6'd23: b = 8'h6C;
			6'd24: b = 8'h20;
			6'd25: b = 8'h43;
			6'd26: b = 8'h68;
			6'd27: b = 8'h61;
			6'd28: b = 8'h6D;
			6'd29: b = 8'h70;
			6'd30: b = 8'h69;
			6'd31: b = 8'h6F;
			6'd32: b = 8'h6E;
			6'd33: b = 8'h73;
			6'd34: b = 8'h20;
			6'd35: b = 8'h55;
			6'd36: b = 8'h43;
			6'd37: b = 8'h46;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/stream_pattern_substitute_append.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_substitute_append
// Write bytes enter one per transfer; a three-byte marker run inside one write
// is replaced by a fixed message, other bytes pass, each result carries its
// append address in the store or a drop flag once the store is full. An input
// transfer can be taken every cycle while the job queue has room. The end of
// a write flushes up to three bytes, and a replacement occupies the back end,
// one rom byte per cycle while the output is not stalled. The front keeps
// taking transfers until the four-entry job queue fills, then holds in_ready
// low. Results are held in the job queue and then leave a registered output
// stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_pattern_substitute_append #(
	parameter int BUFFER_BYTES  = spsa_pkg::BUFFER_BYTES_DEF,
	parameter int MESSAGE_BYTES = spsa_pkg::MESSAGE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        last_of_write,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic [spsa_pkg::ADDR_W-1:0] store_address,
	output logic                        dropped,
	output logic                        last_of_run
);

	spsa_pkg::jobq_status_t q_status;
	spsa_pkg::job_t         push_job;
	spsa_pkg::job_t         head_job;
	logic                   push;
	logic                   pop;

	spsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.last_of_write(last_of_write),
		.q_status     (q_status),
		.push         (push),
		.push_job     (push_job)
	);

	spsa_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.status  (q_status)
	);

	spsa_back #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MESSAGE_BYTES(MESSAGE_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.store_address(store_address),
		.dropped      (dropped),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== rtl/spsa_front.sv =====
// ----------------------------------------------------------------------------
// spsa_front
// look-ahead window, pattern detect and job build for each input transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  last_of_write,
	input  spsa_pkg::jobq_status_t q_status,
	output logic                  push,
	output spsa_pkg::job_t        push_job
);

	logic [1:0][7:0] win_q, win_d;
	logic [1:0]      cnt_q, cnt_d;
	logic            has_job;
	logic            match;
	spsa_pkg::job_t  job;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready && has_job;
	assign push_job = job;

	always_comb begin
		job        = '0;
		job.kind   = spsa_pkg::JOB_BYTES;
		has_job    = 1'b0;
		win_d      = win_q;
		cnt_d      = cnt_q;
		match      = (cnt_q == 2'd2) && (win_q[0] == spsa_pkg::PAT_0)
			&& (win_q[1] == spsa_pkg::PAT_1) && (in_byte == spsa_pkg::PAT_2);
		if (cnt_q == 2'd2) begin
			has_job = 1'b1;
			if (match) begin
				job.kind = spsa_pkg::JOB_MSG;
				cnt_d    = 2'd0;
			end else begin
				job.nbytes   = 2'd1;
				job.bytes[0] = win_q[0];
				win_d[0]     = win_q[1];
				win_d[1]     = in_byte;
				if (last_of_write) begin
					job.nbytes   = 2'd3;
					job.bytes[1] = win_q[1];
					job.bytes[2] = in_byte;
				end
			end
		end else if (last_of_write) begin
			has_job = 1'b1;
			if (cnt_q == 2'd0) begin
				job.nbytes   = 2'd1;
				job.bytes[0] = in_byte;
			end else begin
				job.nbytes   = 2'd2;
				job.bytes[0] = win_q[0];
				job.bytes[1] = in_byte;
			end
		end else begin
			win_d[cnt_q[0]] = in_byte;
			cnt_d           = cnt_q + 2'd1;
		end
		// end of write flushes the window
		if (last_of_write) begin
			cnt_d = 2'd0;
			win_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= 2'd0;
		end else if (in_valid && in_ready) begin
			win_q <= win_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== rtl/spsa_job_queue.sv =====
// ----------------------------------------------------------------------------
// spsa_job_queue
// short job queue between the front and back halves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stream_pattern_substitute_append_assert.svh"

module spsa_job_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  spsa_pkg::job_t         push_job,
	input  logic                   pop,
	output spsa_pkg::job_t         head_job,
	output spsa_pkg::jobq_status_t status
);

	localparam int DEPTH = spsa_pkg::JOBQ_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	spsa_pkg::job_t    entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign head_job     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SPSA_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !status.full)
	`SPSA_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !status.empty)
	`SPSA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))

endmodule

// ===== rtl/spsa_back.sv =====
// ----------------------------------------------------------------------------
// spsa_back
// expands queued jobs into bytes, tracks the store fill level, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stream_pattern_substitute_append_assert.svh"

module spsa_back #(
	parameter int BUFFER_BYTES  = spsa_pkg::BUFFER_BYTES_DEF,
	parameter int MESSAGE_BYTES = spsa_pkg::MESSAGE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spsa_pkg::job_t              head_job,
	input  spsa_pkg::jobq_status_t      q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic [spsa_pkg::ADDR_W-1:0] store_address,
	output logic                        dropped,
	output logic                        last_of_run
);

	localparam int MSG_IDX_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
	localparam int POS_W     = (MSG_IDX_W > 2) ? MSG_IDX_W : 2;
	localparam int FILL_W    = $clog2(BUFFER_BYTES + 1);

	logic [POS_W-1:0]  pos_q;
	logic [FILL_W-1:0] fill_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [spsa_pkg::ADDR_W-1:0] addr_q;
	logic              dropped_q;
	logic              last_q;

	logic              head_valid;
	logic              adv;
	logic              job_end;
	logic              full;
	logic [7:0]        cur_byte;

	assign head_valid = !q_status.empty;
	assign adv        = head_valid && (!out_valid_q || out_ready);
	assign full       = (fill_q == FILL_W'(BUFFER_BYTES));
	assign pop        = adv && job_end;

	always_comb begin
		if (head_job.kind == spsa_pkg::JOB_MSG) begin
			job_end  = (pos_q == POS_W'(MESSAGE_BYTES - 1));
			cur_byte = spsa_pkg::msg_rom_byte(6'(pos_q));
		end else begin
			job_end  = (pos_q == POS_W'(head_job.nbytes - 2'd1));
			cur_byte = head_job.bytes[pos_q[1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				pos_q       <= job_end ? '0 : pos_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= cur_byte;
			last_q     <= job_end;
			dropped_q  <= full;
			addr_q     <= full ? '0 : spsa_pkg::ADDR_W'(fill_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign store_address = addr_q;
	assign dropped       = dropped_q;
	assign last_of_run   = last_q;

	`SPSA_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(BUFFER_BYTES))
	`SPSA_ASSERT_IMP(a_drop_when_full, clk, arst_n, out_valid_q && dropped_q, full)
	`SPSA_ASSERT_NXT(a_mid_job_holds, clk, arst_n, adv && !job_end,
		head_valid && (pos_q != '0))

endmodule
